### design/lc3_instruction_core_assert.svh
// ----------------------------------------------------------------------------
// LC-3 instruction core assertion macros
// Concurrent assertion shorthands clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LC3_INSTRUCTION_CORE_ASSERT_SVH
`define LC3_INSTRUCTION_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define LC3_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define LC3_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LC3_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define LC3_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### design/lc3ic_pkg.sv
// ----------------------------------------------------------------------------
// LC-3 instruction core package
// Shared write-port types, opcodes, trap vectors and helper functions.
// ----------------------------------------------------------------------------
package lc3ic_pkg;

    // Write port of the main memory.
    typedef struct packed {
        logic        en;
        logic [15:0] addr;
        logic [15:0] data;
    } mem_wr_t;

    // Write port of the register file.
    typedef struct packed {
        logic        en;
        logic [2:0]  addr;
        logic [15:0] data;
    } rf_wr_t;

    // Opcodes.
    localparam logic [3:0] OP_BR   = 4'h0;
    localparam logic [3:0] OP_ADD  = 4'h1;
    localparam logic [3:0] OP_LD   = 4'h2;
    localparam logic [3:0] OP_ST   = 4'h3;
    localparam logic [3:0] OP_JSR  = 4'h4;
    localparam logic [3:0] OP_AND  = 4'h5;
    localparam logic [3:0] OP_LDR  = 4'h6;
    localparam logic [3:0] OP_STR  = 4'h7;
    localparam logic [3:0] OP_RTI  = 4'h8;
    localparam logic [3:0] OP_NOT  = 4'h9;
    localparam logic [3:0] OP_LDI  = 4'hA;
    localparam logic [3:0] OP_STI  = 4'hB;
    localparam logic [3:0] OP_JMP  = 4'hC;
    localparam logic [3:0] OP_RES  = 4'hD;
    localparam logic [3:0] OP_LEA  = 4'hE;
    localparam logic [3:0] OP_TRAP = 4'hF;

    // Trap vectors.
    localparam logic [7:0] TV_GETC = 8'h20;
    localparam logic [7:0] TV_OUT  = 8'h21;
    localparam logic [7:0] TV_IN   = 8'h23;
    localparam logic [7:0] TV_HALT = 8'h25;

    // Result status codes.
    localparam logic [1:0] ST_RUN     = 2'd0;
    localparam logic [1:0] ST_HALTED  = 2'd1;
    localparam logic [1:0] ST_ILLEGAL = 2'd2;
    localparam logic [1:0] ST_TRAP    = 2'd3;

    // Keyboard device addresses and reset values.
    localparam logic [15:0] KBSR_ADDR  = 16'hFE00;
    localparam logic [15:0] KBDR_ADDR  = 16'hFE02;
    localparam logic [15:0] KEY_WAIT   = 16'h8000;
    localparam logic [15:0] PC_RESET   = 16'h3000;
    localparam logic [2:0]  FLAG_N     = 3'b100;
    localparam logic [2:0]  FLAG_Z     = 3'b010;
    localparam logic [2:0]  FLAG_P     = 3'b001;

    function automatic logic [15:0] sext9(input logic [15:0] w);
        sext9 = {{7{w[8]}}, w[8:0]};
    endfunction

    function automatic logic [15:0] sext6(input logic [15:0] w);
        sext6 = {{10{w[5]}}, w[5:0]};
    endfunction

    function automatic logic [15:0] sext11(input logic [15:0] w);
        sext11 = {{5{w[10]}}, w[10:0]};
    endfunction

    function automatic logic [15:0] sext5(input logic [15:0] w);
        sext5 = {{11{w[4]}}, w[4:0]};
    endfunction

    // Condition code of a written value.
    function automatic logic [2:0] nzp_of(input logic [15:0] w);
        if (w == 16'h0000)
            nzp_of = FLAG_Z;
        else if (w[15])
            nzp_of = FLAG_N;
        else
            nzp_of = FLAG_P;
    endfunction

endpackage

### design/lc3_instruction_core.sv
// ----------------------------------------------------------------------------
// LC-3 instruction core
// Loads program words and executes one LC-3 instruction per step beat.
//
//  channel | direction | beat contents
//  s_*     | in        | tuser func; tdata load_addr, load_data, key_ready, key_char
//  m_*     | out       | tdata status, char_valid, char_out, key_taken,
//          |           |       trap_vector, next_pc
//  cfg_*   | in        | start_pc write, also loads the program counter
//
// A load beat writes one word of memory. A step runs the fetch, decode and
// execute states for ALU, branch, jump, store, illegal opcodes and traps without
// a key read; LD, LDR, STI and GETC or IN with a key waiting add a memory or
// trap state, LDI adds two memory states, and a keyboard status read that finds
// a key adds a state for the data word write. The single read port of the main
// memory sets this sequence. One input beat is buffered while another executes;
// a full output register stalls the sequencer. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
`include "lc3_instruction_core_assert.svh"

module lc3_instruction_core
    import lc3ic_pkg::*;
#(
    parameter int MEM_WORDS = 65536
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // load_addr, load_data, key_ready, key_char
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status, char_valid, char_out, key_taken,
                                   // trap_vector, next_pc
    input  logic        cfg_wen,
    input  logic [15:0] cfg_wdata
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_EXEC   = 7'b0000100,
        S_KBDR   = 7'b0001000,
        S_MEM1   = 7'b0010000,
        S_MEM2   = 7'b0100000,
        S_TRAP2  = 7'b1000000
    } state_t;

    state_t state_reg, state_next, ret_reg, ret_next;

    logic [15:0] pc_reg, pc_next;
    logic [2:0]  flags_reg, flags_next;
    logic        halted_reg, halted_next;
    logic [15:0] ir_reg, ir_next;
    logic        kb_hit_reg, kb_hit_next;
    logic [15:0] kb_word_reg, kb_word_next;
    logic        key_taken_reg, key_taken_next;
    logic        ck_ready_reg, ck_ready_next;
    logic [7:0]  ck_char_reg, ck_char_next;

    logic        buf_valid_reg;
    logic        buf_func_reg;
    logic [40:0] buf_data_reg;
    logic        buf_take;

    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic        out_cvalid_reg;
    logic [7:0]  out_cout_reg;
    logic        out_ktaken_reg;
    logic [7:0]  out_tvec_reg;
    logic [15:0] out_npc_reg;

    logic [1:0]  res_status;
    logic        res_cvalid;
    logic [7:0]  res_cout;
    logic [7:0]  res_tvec;

    logic        mem_rd_en;
    logic [15:0] mem_rd_addr;
    logic [15:0] mem_rd_data;
    mem_wr_t     mem_wr;

    logic        rf_rd_en;
    logic [2:0]  rf_addr_a;
    logic [2:0]  rf_addr_b;
    logic [15:0] ra;
    logic [15:0] rb;
    rf_wr_t      rf_wr;

    logic        ld_req;
    logic [15:0] ld_addr;
    state_t      ld_cons;

    logic        fin;
    logic        out_free;
    logic        stall;
    logic        kr;
    logic [7:0]  kc;
    logic [15:0] rdata;
    logic [3:0]  op;
    logic [3:0]  dec_op;
    logic [7:0]  vec;
    logic        is_key;
    logic [15:0] alu_b;
    logic [15:0] wval;

    assign s_tready = !buf_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_npc_reg, out_tvec_reg, out_ktaken_reg,
                       out_cout_reg, out_cvalid_reg, out_status_reg};

    assign out_free = !out_valid_reg || m_tready;
    assign rdata    = kb_hit_reg ? kb_word_reg : mem_rd_data;
    assign op       = ir_reg[15:12];
    assign dec_op   = rdata[15:12];
    assign vec      = ir_reg[7:0];
    assign is_key   = (vec == TV_GETC) || (vec == TV_IN);
    assign alu_b    = ir_reg[5] ? sext5(ir_reg) : rb;
    assign kr       = (state_reg == S_IDLE) ? buf_data_reg[32] : ck_ready_reg;
    assign kc       = (state_reg == S_IDLE) ? buf_data_reg[40:33] : ck_char_reg;

    lc3ic_mem #(
        .MEM_WORDS (MEM_WORDS)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr      (mem_wr)
    );

    lc3ic_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (rf_rd_en),
        .rd_addr_a (rf_addr_a),
        .rd_addr_b (rf_addr_b),
        .rd_data_a (ra),
        .rd_data_b (rb),
        .wr        (rf_wr)
    );

    // States that hand a result to the output register.
    always_comb
    begin
        fin = 1'b0;
        unique case (state_reg)
            S_IDLE:
                fin = buf_valid_reg && (!buf_func_reg || halted_reg);
            S_EXEC:
            begin
                if (op == OP_TRAP)
                    fin = !(is_key && ck_ready_reg);
                else
                    fin = (op != OP_LD) && (op != OP_LDR) && (op != OP_LDI) && (op != OP_STI);
            end
            S_MEM1:
                fin = (op != OP_LDI);
            S_MEM2, S_TRAP2:
                fin = 1'b1;
            S_DECODE, S_KBDR:
                fin = 1'b0;
            default:
                fin = 1'b0;
        endcase
    end

    assign stall = fin && !out_free;

    // Sequencer: fetch, decode, execute and memory steps.
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        pc_next        = pc_reg;
        flags_next     = flags_reg;
        halted_next    = halted_reg;
        ir_next        = ir_reg;
        kb_hit_next    = kb_hit_reg;
        kb_word_next   = kb_word_reg;
        key_taken_next = key_taken_reg;
        ck_ready_next  = ck_ready_reg;
        ck_char_next   = ck_char_reg;
        buf_take       = 1'b0;
        res_status     = halted_reg ? ST_HALTED : ST_RUN;
        res_cvalid     = 1'b0;
        res_cout       = 8'h00;
        res_tvec       = 8'h00;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = 16'h0000;
        mem_wr         = '0;
        rf_rd_en       = 1'b0;
        rf_addr_a      = 3'd0;
        rf_addr_b      = 3'd0;
        rf_wr          = '0;
        ld_req         = 1'b0;
        ld_addr        = 16'h0000;
        ld_cons        = S_IDLE;
        wval           = 16'h0000;

        if (!stall)
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (buf_valid_reg)
                    begin
                        buf_take       = 1'b1;
                        ck_ready_next  = buf_data_reg[32];
                        ck_char_next   = buf_data_reg[40:33];
                        key_taken_next = 1'b0;
                        if (!buf_func_reg)
                            mem_wr = '{en: 1'b1, addr: buf_data_reg[15:0],
                                       data: buf_data_reg[31:16]};
                        else if (!halted_reg)
                        begin
                            pc_next = pc_reg + 16'd1;
                            ld_req  = 1'b1;
                            ld_addr = pc_reg;
                            ld_cons = S_DECODE;
                        end
                    end
                end

                S_KBDR:
                begin
                    mem_wr     = '{en: 1'b1, addr: KBDR_ADDR, data: {8'h00, kc}};
                    state_next = ret_reg;
                end

                S_DECODE:
                begin
                    ir_next    = rdata;
                    rf_rd_en   = 1'b1;
                    rf_addr_a  = (dec_op == OP_TRAP) ? 3'd0 : rdata[8:6];
                    rf_addr_b  = ((dec_op == OP_ADD) || (dec_op == OP_AND)) ? rdata[2:0]
                                                                            : rdata[11:9];
                    state_next = S_EXEC;
                end

                S_EXEC:
                begin
                    state_next = S_IDLE;
                    unique case (op)
                        OP_BR:
                            if ((ir_reg[11:9] & flags_reg) != 3'b000)
                                pc_next = pc_reg + sext9(ir_reg);
                        OP_ADD, OP_AND, OP_NOT, OP_LEA:
                        begin
                            if (op == OP_ADD)
                                wval = ra + alu_b;
                            else if (op == OP_AND)
                                wval = ra & alu_b;
                            else if (op == OP_NOT)
                                wval = ~ra;
                            else
                                wval = pc_reg + sext9(ir_reg);
                            rf_wr      = '{en: 1'b1, addr: ir_reg[11:9], data: wval};
                            flags_next = nzp_of(wval);
                        end
                        OP_LD, OP_LDI, OP_STI:
                        begin
                            ld_req  = 1'b1;
                            ld_addr = pc_reg + sext9(ir_reg);
                            ld_cons = S_MEM1;
                        end
                        OP_LDR:
                        begin
                            ld_req  = 1'b1;
                            ld_addr = ra + sext6(ir_reg);
                            ld_cons = S_MEM1;
                        end
                        OP_ST:
                            mem_wr = '{en: 1'b1, addr: pc_reg + sext9(ir_reg), data: rb};
                        OP_STR:
                            mem_wr = '{en: 1'b1, addr: ra + sext6(ir_reg), data: rb};
                        OP_JSR:
                        begin
                            rf_wr   = '{en: 1'b1, addr: 3'd7, data: pc_reg};
                            pc_next = ir_reg[11] ? (pc_reg + sext11(ir_reg)) : ra;
                        end
                        OP_JMP:
                            pc_next = ra;
                        OP_RTI, OP_RES:
                            res_status = ST_ILLEGAL;
                        OP_TRAP:
                        begin
                            res_tvec = vec;
                            if (is_key && !ck_ready_reg)
                                pc_next = pc_reg - 16'd1;
                            else
                            begin
                                rf_wr = '{en: 1'b1, addr: 3'd7, data: pc_reg};
                                if (is_key)
                                    state_next = S_TRAP2;
                                else if (vec == TV_OUT)
                                begin
                                    res_cvalid = 1'b1;
                                    res_cout   = ra[7:0];
                                end
                                else if (vec == TV_HALT)
                                begin
                                    halted_next = 1'b1;
                                    res_status  = ST_HALTED;
                                end
                                else
                                    res_status = ST_TRAP;
                            end
                        end
                        default:
                            res_status = ST_ILLEGAL;
                    endcase
                end

                S_MEM1:
                begin
                    state_next = S_IDLE;
                    if (op == OP_LDI)
                    begin
                        ld_req  = 1'b1;
                        ld_addr = rdata;
                        ld_cons = S_MEM2;
                    end
                    else if (op == OP_STI)
                        mem_wr = '{en: 1'b1, addr: rdata, data: rb};
                    else
                    begin
                        rf_wr      = '{en: 1'b1, addr: ir_reg[11:9], data: rdata};
                        flags_next = nzp_of(rdata);
                    end
                end

                S_MEM2:
                begin
                    state_next = S_IDLE;
                    rf_wr      = '{en: 1'b1, addr: ir_reg[11:9], data: rdata};
                    flags_next = nzp_of(rdata);
                end

                S_TRAP2:
                begin
                    state_next     = S_IDLE;
                    rf_wr          = '{en: 1'b1, addr: 3'd0, data: {8'h00, ck_char_reg}};
                    flags_next     = nzp_of({8'h00, ck_char_reg});
                    key_taken_next = 1'b1;
                    res_tvec       = vec;
                    if (vec == TV_IN)
                    begin
                        res_cvalid = 1'b1;
                        res_cout   = ck_char_reg;
                    end
                end

                default:
                    state_next = S_IDLE;
            endcase

            // Memory load; a keyboard status read updates the device words.
            if (ld_req)
            begin
                if (ld_addr == KBSR_ADDR)
                begin
                    mem_wr       = '{en: 1'b1, addr: KBSR_ADDR,
                                     data: kr ? KEY_WAIT : 16'h0000};
                    kb_hit_next  = 1'b1;
                    kb_word_next = kr ? KEY_WAIT : 16'h0000;
                    if (kr)
                    begin
                        key_taken_next = 1'b1;
                        ret_next       = ld_cons;
                        state_next     = S_KBDR;
                    end
                    else
                        state_next = ld_cons;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = ld_addr;
                    kb_hit_next = 1'b0;
                    state_next  = ld_cons;
                end
            end
        end

        // Start address write reloads the program counter.
        if (cfg_wen)
            pc_next = cfg_wdata;
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            pc_reg        <= PC_RESET;
            flags_reg     <= FLAG_Z;
            halted_reg    <= 1'b0;
            kb_hit_reg    <= 1'b0;
            key_taken_reg <= 1'b0;
            ck_ready_reg  <= 1'b0;
            buf_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            pc_reg        <= pc_next;
            flags_reg     <= flags_next;
            halted_reg    <= halted_next;
            kb_hit_reg    <= kb_hit_next;
            key_taken_reg <= key_taken_next;
            ck_ready_reg  <= ck_ready_next;
            if (s_tvalid && s_tready)
                buf_valid_reg <= 1'b1;
            else if (buf_take)
                buf_valid_reg <= 1'b0;
            if (fin && !stall)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        ir_reg      <= ir_next;
        kb_word_reg <= kb_word_next;
        ck_char_reg <= ck_char_next;
        if (s_tvalid && s_tready)
        begin
            buf_func_reg <= s_tuser;
            buf_data_reg <= s_tdata[40:0];
        end
        if (fin && !stall)
        begin
            out_status_reg <= res_status;
            out_cvalid_reg <= res_cvalid;
            out_cout_reg   <= res_cout;
            out_ktaken_reg <= key_taken_next;
            out_tvec_reg   <= res_tvec;
            out_npc_reg    <= pc_next;
        end
    end

    `LC3_ASSERT_NEXT(a_halt_sticky, halted_reg, halted_reg, "halted core resumed")
    `LC3_ASSERT_IMPLIES(a_key_taken_ready, key_taken_reg, ck_ready_reg,
                        "key taken without a waiting key")
    `LC3_ASSERT_IMPLIES(a_char_running, out_valid_reg && out_cvalid_reg,
                        out_status_reg == ST_RUN, "character emitted with non-running status")

endmodule

### design/lc3ic_mem.sv
// ----------------------------------------------------------------------------
// LC-3 main memory
// Synchronous RAM with one read and one write port; read data is registered
// and a write to the address read in the same cycle is forwarded.
// ----------------------------------------------------------------------------
module lc3ic_mem
    import lc3ic_pkg::*;
#(
    parameter int MEM_WORDS = 65536
)
(
    input  logic        clk,
    input  logic        rd_en,
    input  logic [15:0] rd_addr,
    output logic [15:0] rd_data,
    input  mem_wr_t     wr
);

    // The depth is a power of two, so the address wraps by truncation.
    localparam int AW = $clog2(MEM_WORDS);

    logic [15:0] mem_array [MEM_WORDS];
    logic [15:0] rd_data_reg;
    logic [AW-1:0] rd_idx;
    logic [AW-1:0] wr_idx;

    assign rd_idx  = rd_addr[AW-1:0];
    assign wr_idx  = wr.addr[AW-1:0];
    assign rd_data = rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem_array[wr_idx] <= wr.data;
    end

    // Read port with write-through forwarding.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr.en && (wr_idx == rd_idx))
                rd_data_reg <= wr.data;
            else
                rd_data_reg <= mem_array[rd_idx];
        end
    end

endmodule

### design/lc3ic_regs.sv
// ----------------------------------------------------------------------------
// LC-3 register file
// Eight 16-bit registers, two registered read ports and one write port.
// Valid bits make an unwritten register read as zero after reset.
// ----------------------------------------------------------------------------
module lc3ic_regs
    import lc3ic_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rd_en,
    input  logic [2:0]  rd_addr_a,
    input  logic [2:0]  rd_addr_b,
    output logic [15:0] rd_data_a,
    output logic [15:0] rd_data_b,
    input  rf_wr_t      wr
);

    logic [15:0] reg_array [8];
    logic [7:0]  valid_reg;
    logic [15:0] rd_a_reg;
    logic [15:0] rd_b_reg;
    logic [15:0] word_a;
    logic [15:0] word_b;

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

    // Read values with forwarding from a write in the same cycle.
    always_comb
    begin
        if (wr.en && (wr.addr == rd_addr_a))
            word_a = wr.data;
        else
            word_a = valid_reg[rd_addr_a] ? reg_array[rd_addr_a] : 16'h0000;
        if (wr.en && (wr.addr == rd_addr_b))
            word_b = wr.data;
        else
            word_b = valid_reg[rd_addr_b] ? reg_array[rd_addr_b] : 16'h0000;
    end

    // Valid bits clear at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 8'h00;
        else if (wr.en)
            valid_reg[wr.addr] <= 1'b1;
    end

    // Storage and read registers.
    always_ff @(posedge clk)
    begin
        if (wr.en)
            reg_array[wr.addr] <= wr.data;
        if (rd_en)
        begin
            rd_a_reg <= word_a;
            rd_b_reg <= word_b;
        end
    end

endmodule
